// ----- rtl/mre_pkg.sv -----
package mre_pkg;

    // Default values of the top-level parameters.
    localparam int unsigned RotaryDimDefault    = 128;
    localparam int unsigned MaxPositionsDefault = 256;
    localparam int unsigned MaxHeadSizeDefault  = 256;

    // Fixed field widths.
    localparam int unsigned ActionW    = 2;
    localparam int unsigned TableAddrW = 15;
    localparam int unsigned TableDepth = 1 << TableAddrW;
    localparam int unsigned DataW      = 16;
    localparam int unsigned PosW       = 8;
    localparam int unsigned IndexW     = 8;
    localparam int unsigned SectionW   = 7;
    localparam int unsigned ProdW      = 2 * DataW;
    localparam int unsigned SumW       = ProdW + 1;

    // Configuration port.
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = SectionW;

    localparam logic [SectionW-1:0] SectionTReset = SectionW'(16);
    localparam logic [SectionW-1:0] SectionHReset = SectionW'(24);
    localparam logic                NeoxReset     = 1'b1;

    // Queue between the front and the back.
    localparam int unsigned FifoDepth  = 4;
    localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
    localparam int unsigned FifoCountW = $clog2(FifoDepth + 1);

    // Rounding of the Q7.26 sums to Q4.12.
    localparam int unsigned RoundShift = 14;
    localparam int unsigned BiasedW    = SumW + 1;
    localparam int unsigned QuotW      = BiasedW - RoundShift;

    typedef enum logic [ActionW-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_ROTATE = 2'd1,
        ACT_PASS   = 2'd2
    } t_action;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_SECTION_T = 2'd0,
        CFG_SECTION_H = 2'd1,
        CFG_NEOX      = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_ROTATE,
        KIND_PASS
    } t_kind;

    // One classified transaction as it waits in the queue. For a table
    // write, cos_addr holds the word address and first_value the word.
    typedef struct packed {
        t_kind                    kind;
        logic [TableAddrW-1:0]    cos_addr;
        logic [TableAddrW-1:0]    sin_addr;
        logic [IndexW-1:0]        first_index;
        logic [IndexW-1:0]        second_index;
        logic signed [DataW-1:0]  first_value;
        logic signed [DataW-1:0]  second_value;
    } t_entry;

    typedef struct packed {
        logic signed [DataW-1:0] value;
        logic                    sat;
    } t_rounded;

    // Add one half, floor-shift, then clip to the Q4.12 range.
    function automatic t_rounded round_sat(input logic signed [SumW-1:0] acc);
        logic signed [BiasedW-1:0] biased;
        logic signed [QuotW-1:0]   quot;
        t_rounded                  res;
        biased = BiasedW'(acc) + BiasedW'(signed'(1 << (RoundShift - 1)));
        quot   = QuotW'(biased >>> RoundShift);
        if (quot > QuotW'(signed'(32767))) begin
            res.value = 16'sh7FFF;
            res.sat   = 1'b1;
        end else if (quot < -QuotW'(signed'(32768))) begin
            res.value = 16'sh8000;
            res.sat   = 1'b1;
        end else begin
            res.value = DataW'(quot);
            res.sat   = 1'b0;
        end
        return res;
    endfunction

endpackage

// ----- rtl/mre_in_if.sv -----
interface mre_in_if import mre_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ActionW-1:0]       action;
    logic [TableAddrW-1:0]    table_address;
    logic signed [DataW-1:0]  table_word;
    logic [PosW-1:0]          t_position;
    logic [PosW-1:0]          h_position;
    logic [PosW-1:0]          w_position;
    logic [IndexW-1:0]        index;
    logic signed [DataW-1:0]  first_value;
    logic signed [DataW-1:0]  second_value;

    modport source (
        output valid, action, table_address, table_word, t_position, h_position,
               w_position, index, first_value, second_value,
        input  ready
    );

    modport sink (
        input  valid, action, table_address, table_word, t_position, h_position,
               w_position, index, first_value, second_value,
        output ready
    );
endinterface

// ----- rtl/mre_out_if.sv -----
interface mre_out_if import mre_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IndexW-1:0]        first_index;
    logic signed [DataW-1:0]  first_result;
    logic [IndexW-1:0]        second_index;
    logic signed [DataW-1:0]  second_result;
    logic                     has_second;
    logic                     saturated;

    modport source (
        output valid, first_index, first_result, second_index, second_result,
               has_second, saturated,
        input  ready
    );

    modport sink (
        input  valid, first_index, first_result, second_index, second_result,
               has_second, saturated,
        output ready
    );
endinterface

// ----- rtl/mre_front.sv -----
module mre_front import mre_pkg::*; #(
    parameter int unsigned ROTARY_DIM    = RotaryDimDefault,
    parameter int unsigned MAX_POSITIONS = MaxPositionsDefault,
    parameter int unsigned MAX_HEAD_SIZE = MaxHeadSizeDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    mre_in_if.sink               i_in,
    input  logic                 i_full,
    output logic                 o_push,
    output t_entry               o_entry
);

    localparam int unsigned Half = ROTARY_DIM / 2;

    logic [SectionW-1:0] r_section_t;
    logic [SectionW-1:0] r_section_h;
    logic                r_neox;

    logic [IndexW-1:0]   idx;
    logic [IndexW-1:0]   section_end;
    logic [PosW-1:0]     pos;
    logic [PosW-1:0]     pos_clamped;
    logic [31:0]         row_base;
    logic                keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_t <= SectionTReset;
            r_section_h <= SectionHReset;
            r_neox      <= NeoxReset;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SECTION_T: r_section_t <= i_cfg_data;
                CFG_SECTION_H: r_section_h <= i_cfg_data;
                CFG_NEOX:      r_neox      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        idx         = i_in.index;
        section_end = {1'b0, r_section_t} + {1'b0, r_section_h};

        // The pair index picks which of the three positions selects the row.
        if ({1'b0, idx} < {2'b00, r_section_t}) begin
            pos = i_in.t_position;
        end else if (idx < section_end) begin
            pos = i_in.h_position;
        end else begin
            pos = i_in.w_position;
        end
        pos_clamped = pos;
        if (32'(pos) >= MAX_POSITIONS) begin
            pos_clamped = PosW'(MAX_POSITIONS - 1);
        end
        row_base = 32'(pos_clamped) * ROTARY_DIM;

        keep                 = 1'b0;
        o_entry.kind         = KIND_PASS;
        o_entry.cos_addr     = TableAddrW'(row_base + 32'(idx));
        o_entry.sin_addr     = TableAddrW'(row_base + Half + 32'(idx));
        o_entry.first_index  = idx;
        o_entry.second_index = '0;
        o_entry.first_value  = i_in.first_value;
        o_entry.second_value = i_in.second_value;

        case (t_action'(i_in.action))
            ACT_WRITE: begin
                keep                = 1'b1;
                o_entry.kind        = KIND_WRITE;
                o_entry.cos_addr    = i_in.table_address;
                o_entry.first_value = i_in.table_word;
            end
            ACT_ROTATE: begin
                keep         = 32'(idx) < Half;
                o_entry.kind = KIND_ROTATE;
                if (r_neox) begin
                    o_entry.first_index  = idx;
                    o_entry.second_index = IndexW'(32'(idx) + Half);
                end else begin
                    o_entry.first_index  = {idx[IndexW-2:0], 1'b0};
                    o_entry.second_index = {idx[IndexW-2:0], 1'b1};
                end
            end
            ACT_PASS: begin
                keep                 = 32'(idx) < MAX_HEAD_SIZE;
                o_entry.kind         = KIND_PASS;
                o_entry.second_value = '0;
            end
            default: keep = 1'b0;
        endcase
    end

    // Transactions that give no result and touch no state are taken and dropped.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && keep;

endmodule

// ----- rtl/mre_fifo.sv -----
module mre_fifo import mre_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_head_valid
);

    t_entry                r_slot [FifoDepth];
    logic [FifoPtrW-1:0]   r_wr_ptr;
    logic [FifoPtrW-1:0]   r_rd_ptr;
    logic [FifoCountW-1:0] r_count;
    logic [FifoCountW-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= FifoPtrW'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= FifoPtrW'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full       = r_count == FifoCountW'(FifoDepth);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_slot[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FifoCountW'(FifoDepth))
        else $error("queue count beyond depth");

endmodule

// ----- rtl/mre_back.sv -----
module mre_back import mre_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_entry i_head,
    input  logic   i_head_valid,
    output logic   o_pop,
    mre_out_if.source o_out
);

    logic signed [DataW-1:0] r_table [TableDepth];

    // Stage 1: table read.
    logic                    r_v1;
    logic                    r_rot1;
    logic [IndexW-1:0]       r_i0_1;
    logic [IndexW-1:0]       r_i1_1;
    logic signed [DataW-1:0] r_x0_1;
    logic signed [DataW-1:0] r_x1_1;
    logic signed [DataW-1:0] r_cos;
    logic signed [DataW-1:0] r_sin;

    // Stage 2: products.
    logic                    r_v2;
    logic                    r_rot2;
    logic [IndexW-1:0]       r_i0_2;
    logic [IndexW-1:0]       r_i1_2;
    logic signed [DataW-1:0] r_x0_2;
    logic signed [ProdW-1:0] r_x0c;
    logic signed [ProdW-1:0] r_x1s;
    logic signed [ProdW-1:0] r_x1c;
    logic signed [ProdW-1:0] r_x0s;

    // Stage 3: output register.
    logic                    r_v3;
    logic [IndexW-1:0]       r_first_index;
    logic signed [DataW-1:0] r_first_result;
    logic [IndexW-1:0]       r_second_index;
    logic signed [DataW-1:0] r_second_result;
    logic                    r_has_second;
    logic                    r_saturated;

    logic     en1;
    logic     en2;
    logic     en3;
    t_rounded rnd0;
    t_rounded rnd1;

    assign en3   = !r_v3 || o_out.ready;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_head_valid && en1;

    always_comb begin
        rnd0 = round_sat(SumW'(r_x0c) - SumW'(r_x1s));
        rnd1 = round_sat(SumW'(r_x1c) + SumW'(r_x0s));
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == KIND_WRITE) begin
            r_table[i_head.cos_addr] <= i_head.first_value;
        end
        if (o_pop) begin
            r_cos <= r_table[i_head.cos_addr];
            r_sin <= r_table[i_head.sin_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= o_pop && i_head.kind != KIND_WRITE;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rot1 <= i_head.kind == KIND_ROTATE;
            r_i0_1 <= i_head.first_index;
            r_i1_1 <= i_head.second_index;
            r_x0_1 <= i_head.first_value;
            r_x1_1 <= i_head.second_value;
        end
        if (en2 && r_v1) begin
            r_rot2 <= r_rot1;
            r_i0_2 <= r_i0_1;
            r_i1_2 <= r_i1_1;
            r_x0_2 <= r_x0_1;
            r_x0c  <= r_x0_1 * r_cos;
            r_x1s  <= r_x1_1 * r_sin;
            r_x1c  <= r_x1_1 * r_cos;
            r_x0s  <= r_x0_1 * r_sin;
        end
        if (en3 && r_v2) begin
            r_first_index <= r_i0_2;
            r_has_second  <= r_rot2;
            if (r_rot2) begin
                r_first_result  <= rnd0.value;
                r_second_index  <= r_i1_2;
                r_second_result <= rnd1.value;
                r_saturated     <= rnd0.sat || rnd1.sat;
            end else begin
                r_first_result  <= r_x0_2;
                r_second_index  <= '0;
                r_second_result <= '0;
                r_saturated     <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_v3;
    assign o_out.first_index   = r_first_index;
    assign o_out.first_result  = r_first_result;
    assign o_out.second_index  = r_second_index;
    assign o_out.second_result = r_second_result;
    assign o_out.has_second    = r_has_second;
    assign o_out.saturated     = r_saturated;

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.kind == KIND_WRITE |=> !r_v1)
        else $error("table write entered the datapath");

    a_pass_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_has_second |-> !r_saturated && r_second_result == '0)
        else $error("pass-through result carries rotate fields");

    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !en1 |=> r_v1 && $stable(r_cos) && $stable(r_sin))
        else $error("stalled table read data changed");

endmodule

// ----- rtl/multimodal_rotary_embedding_core.sv -----
// Multimodal rotary position embedding core. Each input transaction either
// writes one Q2.14 word of the cosine/sine table, rotates one element pair
// of an attention head, or passes one element through. A row of the table
// holds ROTARY_DIM words, cosines in the lower half and sines in the upper
// half, and row r starts at word r * ROTARY_DIM (addresses wrap to 15 bits).
// For a rotate, the pair index selects the temporal, height or width
// position by the two section registers, the position is clamped to
// MAX_POSITIONS - 1, and the pair (x0, x1) in Q4.12 becomes
// x0*c - x1*s and x1*c + x0*s, rounded half up and saturated, with a flag
// when either result clips. Table words must be written before they are
// read; the table has no reset. The user must write configuration only
// while the core is idle; the core does not enforce it. Unless stalled by
// a full queue or a not-ready output, it accepts one transaction and gives
// one result per clock, limited by its single table memory, which takes
// one write and two reads each cycle. A result goes through the queue and
// the table read, product and output registers. Table writes, out-of-range
// indices and the unused action code are accepted and produce no result.
module multimodal_rotary_embedding_core import mre_pkg::*; #(
    parameter int unsigned ROTARY_DIM    = RotaryDimDefault,
    parameter int unsigned MAX_POSITIONS = MaxPositionsDefault,
    parameter int unsigned MAX_HEAD_SIZE = MaxHeadSizeDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    mre_in_if.sink               i_in,
    mre_out_if.source            o_out
);

    // The front classifies each transaction, selects the position and forms
    // both table addresses and both output indices.
    logic   push;
    logic   full;
    logic   pop;
    logic   head_valid;
    t_entry push_entry;
    t_entry head_entry;

    mre_front #(
        .ROTARY_DIM    (ROTARY_DIM),
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_HEAD_SIZE (MAX_HEAD_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // A short queue lets the input keep flowing while the output stalls.
    mre_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_head       (head_entry),
        .o_head_valid (head_valid)
    );

    // The back owns the table memory, the four multipliers and the rounding.
    mre_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_entry),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
